// ----- rtl/core/cursor_text_buffer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// cursor text buffer assertion macros
// concurrent checks clocked on i_clk, optionally gated by the active-low reset
// ----------------------------------------------------------------------------
`ifndef CURSOR_TEXT_BUFFER_UNIT_ASSERT_SVH
`define CURSOR_TEXT_BUFFER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// check held outside reset
`define CTB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check held on every edge, reset included
`define CTB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CTB_ASSERT(lbl, prop, msg)
`define CTB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/ctb_pkg.sv -----
// ----------------------------------------------------------------------------
// ctb_pkg
// shared constants, request codes and types of the cursor text buffer
// ----------------------------------------------------------------------------
package ctb_pkg;

    // store size and derived widths
    localparam int CAPACITY = 63;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_LEFT   = 3'd2;
    localparam logic [2:0] REQ_RIGHT  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // status codes
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // byte shown at the cursor
    localparam logic [7:0] MARK_CHAR = 8'd124;

    // result word waiting for the memory data
    typedef struct packed {
        logic valid;
        logic from_mem;
        logic is_mark;
        logic status;
        logic last;
    } t_item;

    // buffer bookkeeping seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] cursor;
        logic [CNT_W-1:0] length;
    } t_seq_status;

endpackage

// ----- rtl/core/cursor_text_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// cursor_text_buffer_unit
// text buffer with a cursor, kept as a gap buffer in one synchronous memory
//
//  channel   direction  role
//  s_axis    in         request: tuser = req_type, tdata = char_in
//  m_axis    out        result: tdata = out_char, tuser = mark/status, tlast
//
// insert, delete and unused codes queue their word when taken; a move left or
// right reads the memory, then writes across the gap, unless the cursor is at
// that end already. a read streams length + 1 words, one per cycle while the
// output is free, each read from the store as it is queued. a new request is
// taken once the previous one has queued its last word. synchronous active-low
// reset empties the text; the store is not cleared. a stalled output holds one
// word in the output register and one queued word, and the sequencer waits.
// ----------------------------------------------------------------------------
module cursor_text_buffer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic [2:0] s_axis_tuser,   // [2:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [0] is_mark, [1] status
    output logic       m_axis_tlast
);
    import ctb_pkg::*;

    `include "cursor_text_buffer_unit_assert.svh"

    t_item             item;
    t_seq_status       stat;
    logic              out_free;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;
    logic              is_mark;
    logic              status;

    // request sequencer
    ctb_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_char_in  (s_axis_tdata),
        .i_out_free (out_free),
        .o_item     (item),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_rd_data  (rd_data),
        .o_stat     (stat)
    );

    // text store
    ctb_text_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register
    ctb_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item),
        .i_rd_data (rd_data),
        .o_free    (out_free),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_is_mark (is_mark),
        .o_status  (status),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tuser = {status, is_mark};

    // checks
    `CTB_ASSERT(a_cursor_in_text, stat.cursor <= stat.length, "cursor beyond end of text")
    `CTB_ASSERT(a_length_bounded, stat.length <= CNT_W'(CAPACITY), "text longer than store")
    `CTB_ASSERT(a_mark_word, (m_axis_tvalid && is_mark) |-> (m_axis_tdata == MARK_CHAR && !status), "bad mark word")
    `CTB_ASSERT(a_no_take_while_queued, (s_axis_tvalid && s_axis_tready) |=> !(item.valid && item.from_mem), "request taken during read")

endmodule

// ----- rtl/core/ctb_text_ram.sv -----
// ----------------------------------------------------------------------------
// ctb_text_ram
// text store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module ctb_text_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ctb_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                 i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ctb_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);
    import ctb_pkg::*;

    logic [7:0] r_mem [CAPACITY];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/ctb_seq.sv -----
// ----------------------------------------------------------------------------
// ctb_seq
// request sequencer: keeps cursor and length over a gap-organised store,
// issues memory reads and writes and queues one result word at a time
// ----------------------------------------------------------------------------
module ctb_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_req_type,
    input  logic [7:0]                 i_char_in,
    input  logic                       i_out_free,
    output ctb_pkg::t_item             o_item,
    output logic                       o_rd_en,
    output logic [ctb_pkg::ADDR_W-1:0] o_rd_addr,
    output logic                       o_wr_en,
    output logic [ctb_pkg::ADDR_W-1:0] o_wr_addr,
    output logic [7:0]                 o_wr_data,
    input  logic [7:0]                 i_rd_data,
    output ctb_pkg::t_seq_status       o_stat
);
    import ctb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MVL  = 2'd1;
    localparam logic [1:0] ST_MVR  = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_length, n_length;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_item            r_item, n_item;

    logic             s1_free;
    logic             accept;
    logic [CNT_W:0]   right_start;
    logic [CNT_W:0]   tail_addr;

    // the right part of the text sits at the top of the store
    assign right_start = (CNT_W + 1)'(CAPACITY) - {1'b0, r_length} + {1'b0, r_cursor};
    // store slot of read position r_idx when it lies right of the cursor
    assign tail_addr   = (CNT_W + 1)'(CAPACITY) - {1'b0, r_length} + {1'b0, r_idx}
                         - (CNT_W + 1)'(1);

    assign s1_free    = !r_item.valid || i_out_free;
    assign o_in_ready = (r_state == ST_IDLE) && s1_free;
    assign accept     = i_in_valid && o_in_ready;

    // next state and memory accesses
    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_length  = r_length;
        n_idx     = r_idx;
        n_item    = r_item;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = i_char_in;
        if (i_out_free) begin
            n_item.valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item = '{valid: 1'b1, from_mem: 1'b0, is_mark: 1'b0,
                               status: STATUS_DONE, last: 1'b1};
                    unique case (i_req_type)
                        REQ_INSERT: begin
                            if (r_length == CNT_W'(CAPACITY)) begin
                                n_item.status = STATUS_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_cursor[ADDR_W-1:0];
                                n_cursor  = r_cursor + 1'b1;
                                n_length  = r_length + 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - 1'b1;
                                n_length = r_length - 1'b1;
                            end
                        end
                        REQ_LEFT: begin
                            if (r_cursor != '0) begin
                                n_item.valid = 1'b0;
                                o_rd_en      = 1'b1;
                                o_rd_addr    = ADDR_W'(r_cursor - 1'b1);
                                n_state      = ST_MVL;
                            end
                        end
                        REQ_RIGHT: begin
                            if (r_cursor != r_length) begin
                                n_item.valid = 1'b0;
                                o_rd_en      = 1'b1;
                                o_rd_addr    = right_start[ADDR_W-1:0];
                                n_state      = ST_MVR;
                            end
                        end
                        REQ_READ: begin
                            n_item.valid = 1'b0;
                            n_idx        = '0;
                            n_state      = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // byte left of the cursor crosses the gap to the right part
            ST_MVL: begin
                o_wr_en   = 1'b1;
                o_wr_addr = ADDR_W'(right_start - (CNT_W + 1)'(1));
                o_wr_data = i_rd_data;
                n_cursor  = r_cursor - 1'b1;
                n_item    = '{valid: 1'b1, from_mem: 1'b0, is_mark: 1'b0,
                              status: STATUS_DONE, last: 1'b1};
                n_state   = ST_IDLE;
            end
            // first byte of the right part crosses the gap to the left
            ST_MVR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cursor[ADDR_W-1:0];
                o_wr_data = i_rd_data;
                n_cursor  = r_cursor + 1'b1;
                n_item    = '{valid: 1'b1, from_mem: 1'b0, is_mark: 1'b0,
                              status: STATUS_DONE, last: 1'b1};
                n_state   = ST_IDLE;
            end
            // one word per cycle while the output register is free: left part, mark, right part
            ST_READ: begin
                if (s1_free) begin
                    n_item = '{valid: 1'b1, from_mem: (r_idx != r_cursor),
                               is_mark: (r_idx == r_cursor), status: STATUS_DONE,
                               last: (r_idx == r_length)};
                    o_rd_en = (r_idx != r_cursor);
                    if (r_idx < r_cursor) begin
                        o_rd_addr = r_idx[ADDR_W-1:0];
                    end else begin
                        o_rd_addr = tail_addr[ADDR_W-1:0];
                    end
                    n_idx = r_idx + 1'b1;
                    if (r_idx == r_length) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
            r_length <= '0;
            r_idx    <= '0;
            r_item   <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
            r_idx    <= n_idx;
            r_item   <= n_item;
        end
    end

    assign o_item        = r_item;
    assign o_stat.cursor = r_cursor;
    assign o_stat.length = r_length;

endmodule

// ----- rtl/core/ctb_out_stage.sv -----
// ----------------------------------------------------------------------------
// ctb_out_stage
// output register: joins the queued word with the memory data and holds it
// until the downstream side takes it
// ----------------------------------------------------------------------------
module ctb_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ctb_pkg::t_item i_item,
    input  logic [7:0]     i_rd_data,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_is_mark,
    output logic           o_status,
    output logic           o_last
);
    import ctb_pkg::*;

    logic       r_valid;
    logic [7:0] r_char;
    logic       r_is_mark;
    logic       r_status;
    logic       r_last;
    logic [7:0] n_char;
    logic       load;

    assign load   = i_item.valid && (!r_valid || i_ready);
    assign o_free = !r_valid || i_ready;

    // byte of the word
    always_comb begin
        priority if (i_item.is_mark) begin
            n_char = MARK_CHAR;
        end else if (i_item.from_mem) begin
            n_char = i_rd_data;
        end else begin
            n_char = 8'd0;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char    <= n_char;
            r_is_mark <= i_item.is_mark;
            r_status  <= i_item.status;
            r_last    <= i_item.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_char    = r_char;
    assign o_is_mark = r_is_mark;
    assign o_status  = r_status;
    assign o_last    = r_last;

endmodule
